### sv/transfer_order_cost_selector_macros.svh
// assertion helpers for the transfer order cost selector
`ifndef TRANSFER_ORDER_COST_SELECTOR_MACROS_SVH
`define TRANSFER_ORDER_COST_SELECTOR_MACROS_SVH
`define TOCS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define TOCS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

### sv/tocs_pkg.sv
// ----------------------------------------------------------------------------
// tocs_pkg
// types and constants shared by the cost selector modules
// ----------------------------------------------------------------------------
package tocs_pkg;
    localparam int REGION_PAGES = 512;
    localparam int MAX_ORDER    = 9;
    localparam int NWORDS       = REGION_PAGES / 64;
    localparam int WIDX_W       = $clog2(NWORDS);
    localparam int PAGE_W       = $clog2(REGION_PAGES);
    localparam int ORD_W        = 4;
    localparam int NORD         = MAX_ORDER + 1;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int DIV_W        = 64;
    localparam int CNT_W        = $clog2(REGION_PAGES + 1);
    localparam logic [63:0] BYTE_NUM = 64'd4096000000000;
    localparam logic [9:0]  PERMILLE = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_FIXED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYST  = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_BC_START, S_BC_WAIT, S_ORD, S_CNT, S_FRAC,
        S_C_START, S_C_WAIT, S_CMP, S_DONE, S_OUT
    } state_t;

    typedef struct packed {
        logic            start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;
endpackage

### sv/tocs_if.sv
// ----------------------------------------------------------------------------
// tocs_in_if / tocs_out_if
// valid/ready channels carrying load and query beats in and result beats out
// ----------------------------------------------------------------------------
interface tocs_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [2:0]  word_index;
    logic [63:0] word_data;
    logic [8:0]  page_index;
    logic [3:0]  folio_log2;
    logic [3:0]  current_order;
    logic [9:0]  allowed_orders;
    modport source (output valid, opcode, word_index, word_data, page_index,
                    folio_log2, current_order, allowed_orders, input ready);
    modport sink (input valid, opcode, word_index, word_data, page_index,
                  folio_log2, current_order, allowed_orders, output ready);
endinterface

interface tocs_out_if;
    logic       valid;
    logic       ready;
    logic       decided;
    logic [3:0] chosen_order;
    modport source (output valid, decided, chosen_order, input ready);
    modport sink (input valid, decided, chosen_order, output ready);
endinterface

### sv/tocs_divider.sv
// ----------------------------------------------------------------------------
// tocs_divider
// restoring 64-bit divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tocs_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  tocs_pkg::div_req_t req,
    output tocs_pkg::div_rsp_t rsp
);
    import tocs_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = 7'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where dividend bits leave
            if (!trial[DIV_W])
                rem_next = trial[DIV_W-1:0];
            else
                rem_next = shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ~trial[DIV_W]};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

### sv/tocs_bitmap.sv
// ----------------------------------------------------------------------------
// tocs_bitmap
// touched-page bitmap words with a shared one-word popcount
// ----------------------------------------------------------------------------
module tocs_bitmap (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [tocs_pkg::WIDX_W-1:0]  wr_idx,
    input  logic [63:0]                  wr_data,
    input  logic [tocs_pkg::WIDX_W-1:0]  rd_idx,
    input  logic [63:0]                  rd_mask,
    input  logic [5:0]                   rd_shift,
    output logic [6:0]                   rd_count
);
    import tocs_pkg::*;

    logic [63:0] words_reg [NWORDS];
    logic [63:0] sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NWORDS; i++)
                words_reg[i] <= '0;
        end
        else if (wr_en)
            words_reg[wr_idx] <= wr_data;
    end

    always_comb
    begin
        sel      = (words_reg[rd_idx] >> rd_shift) & rd_mask;
        rd_count = 7'($countones(sel));
    end
endmodule

### sv/transfer_order_cost_selector.sv
// ----------------------------------------------------------------------------
// transfer_order_cost_selector
// picks the cheapest transfer order, or by hysteresis the current one, for a page from a touched bitmap
// ----------------------------------------------------------------------------
// in carries load beats (opcode 0, write one 64-bit bitmap word) and query
// beats (opcode 1). a load gives no result and leaves the block idle, so
// loads can follow each other with no gap. a query gives one result beat on
// out: decided and chosen_order. in is not ready while a query runs.
// a query runs on one shared 64-bit restoring divider: one division for the
// byte cost, then for each tried order a popcount pass over one to eight
// bitmap words, the touched fraction by a shift and one division for the
// bandwidth term. with zero bandwidth no division runs and the result is
// valid in the cycle after the beat is taken; with no byte cost only the
// byte cost division runs. the result is then undecided.
// the result sits in an output register until out takes it; a stall on
// out holds the block, which accepts the next beat the cycle after.
// reset clears the bitmap to all zeros and loads the register defaults
// (7000, 12288, 50, 900). configuration is a write port: cfg_we, cfg_index,
// cfg_data.
// ----------------------------------------------------------------------------
module transfer_order_cost_selector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tocs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tocs_pkg::CFG_W-1:0]      cfg_data,
    tocs_in_if.sink                         in_ch,
    tocs_out_if.source                      out_ch
);
    import tocs_pkg::*;

    logic [31:0] fixed_reg, bw_reg;
    logic [9:0]  minf_reg, hyst_reg;

    state_t state_reg, state_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [ORD_W-1:0]  maxo_reg, maxo_next, cur_reg, cur_next;
    logic [ORD_W-1:0]  o_reg, o_next, best_reg, best_next;
    logic [9:0]        allow_reg, allow_next;
    logic [63:0]       bc_reg, bc_next, f_reg, f_next;
    logic [63:0]       low_cost_reg, low_cost_next, held_cost_reg, held_cost_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIDX_W:0]   wi_reg, wi_next;
    logic              decided_reg, decided_next;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [WIDX_W-1:0] rd_idx;
    logic [63:0]       rd_mask;
    logic [5:0]        rd_shift;
    logic [6:0]        rd_count;
    logic [9:0]        minf_sat, hyst_sat;
    logic [PAGE_W-1:0] start_page;
    logic [WIDX_W:0]   nwords_span;
    logic [63:0]       cost;
    logic [31:0]       frac;
    logic [73:0]       lhs, rhs;
    logic              load_fire;

    assign minf_sat = (minf_reg > PERMILLE) ? PERMILLE : minf_reg;
    assign hyst_sat = (hyst_reg > PERMILLE) ? PERMILLE : hyst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_reg <= 32'd7000;
            bw_reg    <= 32'd12288;
            minf_reg  <= 10'd50;
            hyst_reg  <= 10'd900;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIXED: fixed_reg <= cfg_data;
                REG_BW:    bw_reg    <= cfg_data;
                REG_MINF:  minf_reg  <= cfg_data[9:0];
                REG_HYST:  hyst_reg  <= cfg_data[9:0];
                default:   ;
            endcase
        end
    end

    assign load_fire = in_ch.valid && in_ch.ready && (in_ch.opcode == OP_LOAD);

    // span geometry for order o_reg
    always_comb
    begin
        start_page  = page_reg & ~PAGE_W'((1 << o_reg) - 1);
        nwords_span = (o_reg >= 4'd6) ? (WIDX_W+1)'(1 << (o_reg - 4'd6)) : (WIDX_W+1)'(1);
        if (o_reg < 4'd6)
        begin
            rd_idx   = start_page[PAGE_W-1:6];
            rd_shift = start_page[5:0];
            rd_mask  = (64'd1 << (1 << o_reg)) - 64'd1;
        end
        else
        begin
            rd_idx   = WIDX_W'(start_page[PAGE_W-1:6] + WIDX_W'(wi_reg));
            rd_shift = '0;
            rd_mask  = '1;
        end
    end

    tocs_bitmap u_bitmap (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_fire),
        .wr_idx   (in_ch.word_index),
        .wr_data  (in_ch.word_data),
        .rd_idx   (rd_idx),
        .rd_mask  (rd_mask),
        .rd_shift (rd_shift),
        .rd_count (rd_count)
    );

    tocs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // span length is a power of two, so the fraction is a shift
    assign frac = (32'(cnt_reg) * 32'(PERMILLE)) >> o_reg;
    assign cost = 64'(fixed_reg >> o_reg) + drsp.quo;
    assign lhs  = 74'(low_cost_reg) * 74'(PERMILLE);
    assign rhs  = 74'(held_cost_reg) * 74'(hyst_sat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        maxo_reg      <= maxo_next;
        cur_reg       <= cur_next;
        o_reg         <= o_next;
        best_reg      <= best_next;
        allow_reg     <= allow_next;
        bc_reg        <= bc_next;
        f_reg         <= f_next;
        low_cost_reg  <= low_cost_next;
        held_cost_reg <= held_cost_next;
        cur_valid_reg <= cur_valid_next;
        cnt_reg       <= cnt_next;
        wi_reg        <= wi_next;
        decided_reg   <= decided_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        page_next      = page_reg;
        maxo_next      = maxo_reg;
        cur_next       = cur_reg;
        o_next         = o_reg;
        best_next      = best_reg;
        allow_next     = allow_reg;
        bc_next        = bc_reg;
        f_next         = f_reg;
        low_cost_next  = low_cost_reg;
        held_cost_next = held_cost_reg;
        cur_valid_next = cur_valid_reg;
        cnt_next       = cnt_reg;
        wi_next        = wi_reg;
        decided_next   = decided_reg;
        dreq.start     = 1'b0;
        dreq.num       = BYTE_NUM;
        dreq.den       = {12'd0, bw_reg, 20'd0};
        in_ch.ready    = (state_reg == S_IDLE);
        out_ch.valid   = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.opcode == OP_QUERY)
                begin
                    page_next      = in_ch.page_index;
                    maxo_next      = (in_ch.folio_log2 > 4'(MAX_ORDER)) ?
                                     4'(MAX_ORDER) : in_ch.folio_log2;
                    cur_next       = in_ch.current_order;
                    allow_next     = in_ch.allowed_orders;
                    decided_next   = 1'b0;
                    best_next      = '0;
                    cur_valid_next = 1'b0;
                    low_cost_next  = '1;
                    held_cost_next = '0;
                    o_next         = '0;
                    state_next     = (bw_reg == 32'd0) ? S_OUT : S_BC_START;
                end
            end
            S_BC_START:
            begin
                dreq.start = 1'b1;
                state_next = S_BC_WAIT;
            end
            S_BC_WAIT:
            begin
                if (drsp.done)
                begin
                    bc_next    = drsp.quo;
                    state_next = (drsp.quo == 64'd0) ? S_OUT : S_ORD;
                end
            end
            S_ORD:
            begin
                if (o_reg > maxo_reg)
                    state_next = S_DONE;
                else if (o_reg == 4'd1 || (o_reg != 4'd0 && !allow_reg[o_reg]))
                    o_next = o_reg + 4'd1;
                else
                begin
                    cnt_next   = '0;
                    wi_next    = '0;
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                // one bitmap word per cycle, wrapping across the region
                cnt_next = cnt_reg + CNT_W'(rd_count);
                wi_next  = wi_reg + 1'b1;
                if (wi_reg + 1'b1 == nwords_span)
                    state_next = S_FRAC;
            end
            S_FRAC:
            begin
                f_next = 64'(frac);
                if (frac < 32'(minf_sat))
                    f_next = 64'(minf_sat);
                if (frac == 32'd0 && minf_sat == 10'd0)
                    f_next = 64'd1;
                state_next = S_C_START;
            end
            S_C_START:
            begin
                dreq.start = 1'b1;
                dreq.num   = bc_reg * 64'(PERMILLE);
                dreq.den   = f_reg;
                state_next = S_C_WAIT;
            end
            S_C_WAIT:
            begin
                if (drsp.done)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cost <= low_cost_reg)
                begin
                    low_cost_next = cost;
                    best_next     = o_reg;
                end
                if (o_reg == cur_reg)
                begin
                    held_cost_next = cost;
                    cur_valid_next = 1'b1;
                end
                o_next     = o_reg + 4'd1;
                state_next = S_ORD;
            end
            S_DONE:
            begin
                decided_next = 1'b1;
                if (cur_valid_reg && best_reg != cur_reg && lhs > rhs)
                    best_next = cur_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_ch.decided      = decided_reg;
    assign out_ch.chosen_order = decided_reg ? best_reg : 4'd0;
endmodule

### sv/tocs_checker.sv
// ----------------------------------------------------------------------------
// tocs_checker
// port-level checks on the cost selector, bound to the top level
// ----------------------------------------------------------------------------
`include "transfer_order_cost_selector_macros.svh"
module tocs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_decided,
    input logic [3:0] out_chosen_order
);
    import tocs_pkg::*;

    `TOCS_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, !in_ready)
    `TOCS_ASSERT_IMPL(a_order_range, clk, rst_n, out_valid,
        out_chosen_order <= 4'(MAX_ORDER))
    `TOCS_ASSERT_IMPL(a_undecided_zero, clk, rst_n, out_valid && !out_decided,
        out_chosen_order == 4'd0)
    `TOCS_ASSERT_NEXT(a_query_busy, clk, rst_n,
        in_valid && in_ready && in_opcode == OP_QUERY, !in_ready)
    `TOCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_chosen_order))
endmodule

bind transfer_order_cost_selector tocs_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_opcode        (in_ch.opcode),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_decided      (out_ch.decided),
    .out_chosen_order (out_ch.chosen_order)
);

### tb/tb_transfer_order_cost_selector.sv
// ----------------------------------------------------------------------------
// tb_transfer_order_cost_selector
// self-checking bench: bitmap loads and order queries with random idling
// ----------------------------------------------------------------------------
// a local cost predictor keeps its own bitmap and register copies, works out
// the decision for each accepted query and queues it. result beats are
// compared in order against that queue. registers are rewritten between
// phases while the block is idle, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_transfer_order_cost_selector;
    import tocs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct {
        logic        opcode;
        logic [2:0]  word_index;
        logic [63:0] word_data;
        logic [8:0]  page_index;
        logic [3:0]  folio_log2;
        logic [3:0]  current_order;
        logic [9:0]  allowed_orders;
    } beat_t;

    typedef struct {
        logic       decided;
        logic [3:0] chosen_order;
    } decision_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    tocs_in_if  in_ch ();
    tocs_out_if out_ch ();

    transfer_order_cost_selector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // predictor copies of the bitmap and the registers
    logic [63:0] bitmap_copy [NWORDS];
    logic [31:0] fixed_cost_q;
    logic [31:0] bandwidth_q;
    logic [9:0]  min_frac_q;
    logic [9:0]  hyst_q;

    decision_t decisions_due [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int mismatches;
    int results_seen;
    int loads_sent;
    int queries_sent;
    int undecided_seen;
    int cfg_writes;
    int quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned count_touched(int unsigned start, int unsigned nr);
        int unsigned w;
        int unsigned cnt;
        logic [63:0] word;
        w = start / 64;
        cnt = 0;
        if (nr < 64)
        begin
            word = bitmap_copy[w % NWORDS] >> (start % 64);
            word &= (64'd1 << nr) - 64'd1;
            return $countones(word);
        end
        for (int i = 0; i < nr / 64; i++)
            cnt += $countones(bitmap_copy[(w + i) % NWORDS]);
        return cnt;
    endfunction

    function automatic decision_t pick_order(beat_t b);
        decision_t d;
        longint unsigned xfer_ns;
        longint unsigned low_cost;
        longint unsigned held_cost;
        longint unsigned f;
        longint unsigned cost;
        int unsigned base;
        int unsigned top_order;
        int unsigned nr;
        int unsigned start;
        int unsigned minf;
        int unsigned hyst;
        int unsigned best;
        bit cur_tried;
        d.decided = 1'b0;
        d.chosen_order = 4'd0;
        held_cost = 0;
        best = 0;
        cur_tried = 1'b0;
        if (bandwidth_q == 32'd0)
            return d;
        xfer_ns = 64'd4096000000000 / ({32'd0, bandwidth_q} << 20);
        if (xfer_ns == 0)
            return d;
        base = b.page_index % REGION_PAGES;
        top_order = (b.folio_log2 > MAX_ORDER) ? MAX_ORDER : b.folio_log2;
        minf = (min_frac_q > 1000) ? 1000 : min_frac_q;
        hyst = (hyst_q > 1000) ? 1000 : hyst_q;
        low_cost = '1;
        for (int unsigned o = 0; o <= top_order; o++)
        begin
            if (o == 1)
                continue;
            if (o != 0 && !b.allowed_orders[o])
                continue;
            nr = 1 << o;
            start = base & ~(nr - 1);
            f = longint'(count_touched(start, nr)) * 1000 / nr;
            if (f < minf)
                f = minf;
            if (f == 0)
                f = 1;
            cost = ({32'd0, fixed_cost_q} >> o) + (xfer_ns * 1000) / f;
            if (cost <= low_cost)
            begin
                low_cost = cost;
                best = o;
            end
            if (o == b.current_order)
            begin
                held_cost = cost;
                cur_tried = 1'b1;
            end
        end
        if (cur_tried && best != b.current_order && low_cost * 1000 > held_cost * hyst)
            best = b.current_order;
        d.decided = 1'b1;
        d.chosen_order = best[3:0];
        return d;
    endfunction

    // one beat on the input channel; valid stays high for a following beat
    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= b.opcode;
        in_ch.word_index     <= b.word_index;
        in_ch.word_data      <= b.word_data;
        in_ch.page_index     <= b.page_index;
        in_ch.folio_log2     <= b.folio_log2;
        in_ch.current_order  <= b.current_order;
        in_ch.allowed_orders <= b.allowed_orders;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (b.opcode == OP_LOAD)
        begin
            bitmap_copy[b.word_index % NWORDS] = b.word_data;
            loads_sent++;
        end
        else
        begin
            decisions_due.push_back(pick_order(b));
            queries_sent++;
        end
    endtask

    // valid drops at the edge of the last accepted beat
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (decisions_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_FIXED: fixed_cost_q = value;
            REG_BW:    bandwidth_q  = value;
            REG_MINF:  min_frac_q   = value[9:0];
            REG_HYST:  hyst_q       = value[9:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] fixed, logic [31:0] bw, logic [9:0] minf,
                            logic [9:0] hyst);
        wait_idle();
        write_reg(REG_FIXED, fixed);
        write_reg(REG_BW, bw);
        write_reg(REG_MINF, {22'd0, minf});
        write_reg(REG_HYST, {22'd0, hyst});
    endtask

    function automatic beat_t load_beat(logic [2:0] idx, logic [63:0] data);
        beat_t b;
        b.opcode = OP_LOAD;
        b.word_index = idx;
        b.word_data = data;
        b.page_index = 9'($urandom);
        b.folio_log2 = 4'($urandom);
        b.current_order = 4'($urandom);
        b.allowed_orders = 10'($urandom);
        return b;
    endfunction

    function automatic beat_t query_beat(logic [8:0] page, logic [3:0] folio,
                                         logic [3:0] cur, logic [9:0] allowed);
        beat_t b;
        b.opcode = OP_QUERY;
        b.word_index = 3'($urandom);
        b.word_data = {$urandom, $urandom};
        b.page_index = page;
        b.folio_log2 = folio;
        b.current_order = cur;
        b.allowed_orders = allowed;
        return b;
    endfunction

    function automatic logic [63:0] random_word();
        case ($urandom_range(4))
            0: return 64'd0;
            1: return '1;
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: return ~({$urandom, $urandom} & {$urandom, $urandom});
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic beat_t random_beat();
        if ($urandom_range(99) < 35)
            return load_beat(3'($urandom), random_word());
        return query_beat(9'($urandom), 4'($urandom_range(15)),
                          4'($urandom_range(15)), 10'($urandom));
    endfunction

    task automatic random_regs();
        logic [31:0] fixed;
        logic [31:0] bw;
        case ($urandom_range(5))
            0: fixed = 32'd0;
            1: fixed = '1;
            default: fixed = $urandom_range(200000);
        endcase
        case ($urandom_range(9))
            0: bw = 32'd0;
            1: bw = $urandom_range(32'hFFFFFFFF, 32'd3906251);
            2: bw = 32'd1;
            default: bw = $urandom_range(100000, 100);
        endcase
        set_regs(fixed, bw, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // empty bitmap at reset defaults
        send_beat(query_beat(9'd0, 4'd0, 4'd0, 10'd0));
        send_beat(query_beat(9'd511, 4'd15, 4'd15, 10'h3FF));
        for (int i = 0; i < NWORDS; i++)
            send_beat(load_beat(3'(i), (i % 2) ? '1 : 64'h8000_0000_0000_0001));
        send_beat(query_beat(9'd511, 4'd9, 4'd1, 10'h3FF));
        send_beat(query_beat(9'd64, 4'd15, 4'd0, 10'h3FC));
        send_beat(query_beat(9'd255, 4'd9, 4'd9, 10'h200));
        send_beat(query_beat(9'd1, 4'd6, 4'd10, 10'h001));
        // min fraction and hysteresis saturate, zero clamp, zero fixed cost
        set_regs(32'd0, 32'd1, 10'd1023, 10'd1023);
        send_beat(query_beat(9'd300, 4'd9, 4'd3, 10'h3FF));
        set_regs('1, 32'd3906250, 10'd0, 10'd0);
        send_beat(query_beat(9'd0, 4'd9, 4'd0, 10'h3FF));
        send_beat(query_beat(9'd130, 4'd7, 4'd7, 10'h0FF));
        // no byte cost: zero bandwidth and bandwidth too large
        set_regs(32'd7000, 32'd0, 10'd50, 10'd900);
        send_beat(query_beat(9'd5, 4'd9, 4'd2, 10'h3FF));
        set_regs(32'd7000, 32'd3906251, 10'd50, 10'd900);
        send_beat(query_beat(9'd5, 4'd9, 4'd2, 10'h3FF));
        set_regs(32'd7000, '1, 10'd1000, 10'd1000);
        send_beat(query_beat(9'd5, 4'd9, 4'd2, 10'h3FF));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < 2; k++)
        begin
            random_regs();
            for (int i = 0; i < n / 2; i++)
                send_beat(random_beat());
        end
    endtask

    task automatic test_backpressure();
        set_regs(32'd7000, 32'd12288, 10'd50, 10'd900);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 3000;
        for (int i = 0; i < 20; i++)
            send_beat(query_beat(9'($urandom), 4'($urandom_range(3)),
                                 4'($urandom), 10'($urandom)));
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (!out_ch.decided)
                undecided_seen++;
            if (decisions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: decided=%0b order=%0d",
                             out_ch.decided, out_ch.chosen_order);
            end
            else
            begin
                want = decisions_due.pop_front();
                if (out_ch.decided !== want.decided ||
                    out_ch.chosen_order !== want.chosen_order)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected decided=%0b order=%0d, ",
                                  "got decided=%0b order=%0d"},
                                 results_seen, want.decided, want.chosen_order,
                                 out_ch.decided, out_ch.chosen_order);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", decisions_due.size());
            $display("transfer_order_cost_selector: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_LOAD;
        in_ch.word_index = '0;
        in_ch.word_data = '0;
        in_ch.page_index = '0;
        in_ch.folio_log2 = '0;
        in_ch.current_order = '0;
        in_ch.allowed_orders = '0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        results_seen = 0;
        loads_sent = 0;
        queries_sent = 0;
        undecided_seen = 0;
        cfg_writes = 0;
        quiet_cycles = 0;
        for (int i = 0; i < NWORDS; i++)
            bitmap_copy[i] = 64'd0;
        fixed_cost_q = 32'd7000;
        bandwidth_q = 32'd12288;
        min_frac_q = 10'd50;
        hyst_q = 10'd900;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 380);
        test_random_phase(55, 0, 370);
        test_random_phase(0, 55, 370);
        test_random_phase(35, 35, 370);
        test_backpressure();
        wait_idle();

        $display("covered %0d bitmap loads and %0d queries (%0d undecided)",
                 loads_sent, queries_sent, undecided_seen);
        $display("%0d register writes, %0d result beats checked, %0d mismatches",
                 cfg_writes, results_seen, mismatches);
        if (mismatches == 0 && decisions_due.size() == 0)
            $display("transfer_order_cost_selector: match");
        else
            $display("transfer_order_cost_selector: mismatch");
        $finish;
    end
endmodule
